@@ hdl/lmmf_pkg.sv @@
// Shared types, constants and helper functions for the lidar median/mean filter.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package lmmf_pkg;

  // Ring depth and the widths that follow from it
  localparam int WIN_MAX = 5;
  localparam int IDX_W   = $clog2(WIN_MAX);
  localparam int CNT_W   = $clog2(WIN_MAX + 1);
  localparam int SUM_W   = 16 + $clog2(WIN_MAX);

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Configuration register indexes
  localparam logic [2:0] CFG_MEDIAN_WIN = 3'd0;
  localparam logic [2:0] CFG_MEAN_WIN   = 3'd1;
  localparam logic [2:0] CFG_TEMP_SCALE = 3'd2;
  localparam logic [2:0] CFG_DIST_OFS   = 3'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]  MEDIAN_WIN_RST = 8'd5;
  localparam logic [7:0]  MEAN_WIN_RST   = 8'd5;
  localparam logic [15:0] TEMP_SCALE_RST = 16'd256;
  localparam logic [15:0] DIST_OFS_RST   = 16'd0;

  // Temperature: tenths = product / 2560, clamped to -40.0 .. 125.0 degrees
  localparam logic [31:0]        PROD_LO_LIM = 32'd1024000;   // 400 * 2560
  localparam logic [31:0]        PROD_HI_LIM = 32'd3200000;   // 1250 * 2560
  localparam logic [32:0]        ROUND_HALF  = 33'd1280;
  localparam logic [MUL_B_W-1:0] DIV5_Q16    = 22'd13108;     // ceil(2^16 / 5)
  localparam logic signed [11:0] TEMP_HI     = 12'sd1250;
  localparam logic signed [11:0] TEMP_LO     = -12'sd400;
  localparam logic signed [11:0] TEMP_DFLT   = 12'sd250;      // 25.0 degrees

  // Distance saturation bound
  localparam logic signed [17:0] DIST_MAX = 18'sd65535;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TMUL,
    ST_TRND,
    ST_TDIV,
    ST_TFIN,
    ST_LOAD,
    ST_PICK,
    ST_SCAN,
    ST_MDIV,
    ST_MFIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               read_ok;
    logic [15:0]        distance_raw;
    logic [15:0]        strength_raw;
    logic signed [15:0] temperature_raw;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        distance_out;
    logic [15:0]        strength_out;
    logic [15:0]        distance_filtered;
    logic [15:0]        strength_filtered;
    logic signed [11:0] temperature_tenths;
    logic               frame_ready;
  } out_item_t;

  // Requested window clamped to 1..WIN_MAX
  function automatic logic [CNT_W-1:0] clamp_win(input logic [7:0] w);
    if (w == 8'd0) begin
      return CNT_W'(1);
    end else if (w > 8'(WIN_MAX)) begin
      return CNT_W'(WIN_MAX);
    end else begin
      return w[CNT_W-1:0];
    end
  endfunction

  // Reciprocal of the mean count in Q21; floor((s * r) >> 21) == s / n for s < 2^SUM_W
  function automatic logic [MUL_B_W-1:0] recip_q21(input logic [CNT_W-1:0] n);
    logic [MUL_B_W-1:0] r;
    case (n)
      CNT_W'(1): r = 22'd2097152;
      CNT_W'(2): r = 22'd1048576;
      CNT_W'(3): r = 22'd699051;
      CNT_W'(4): r = 22'd524288;
      CNT_W'(5): r = 22'd419431;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/lmmf_if.sv @@
// Valid/ready channel interfaces for the filter's input and result beats.
// Payload types come from lmmf_pkg.
`timescale 1ns / 1ps

interface lmmf_in_if;
  logic                valid;
  logic                ready;
  lmmf_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lmmf_out_if;
  logic                valid;
  logic                ready;
  lmmf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/lidar_median_mean_filter_core.sv @@
// Top level of the lidar filter: median/mean rings, temperature scaling, distance offset.
// Uses lmmf_pkg and the channel interfaces in lmmf_if.sv.
// Good reading: temperature multiply and round, then divide and finish unless clamped;
//   ring load of the filled entries, median selection passes, mean divide, mean finish, result.
// Failed reading: goes straight to the result state; the result is registered once the output is free.
// One reading at a time: the next beat can be taken in the cycle after the result loads;
//   the median compare loop and the shared multiplier set the time per good reading.
// Synchronous active-low reset; rings are not cleared (only filled entries are read).
`timescale 1ns / 1ps

module lidar_median_mean_filter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  lmmf_in_if.sink              in_ch,
  lmmf_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam int IDX_W = lmmf_pkg::IDX_W;
  localparam int CNT_W = lmmf_pkg::CNT_W;
  localparam int WIN   = lmmf_pkg::WIN_MAX;

  lmmf_pkg::state_t state_r, state_nxt;

  // configuration
  logic [7:0]         median_win_r;
  logic [7:0]         mean_win_r;
  logic [15:0]        temp_scale_r;
  logic signed [15:0] dist_ofs_r;

  // filter state
  logic [15:0]        dring_r [WIN];
  logic [15:0]        sring_r [WIN];
  logic [CNT_W-1:0]   fill_r;
  logic [IDX_W-1:0]   ws_r;
  logic [15:0]        last_median_r;
  logic [15:0]        last_mean_r;
  logic signed [11:0] last_temp_r;

  // per-reading work registers
  lmmf_pkg::in_item_t        item_r;
  logic [CNT_W-1:0]          n_med_r;
  logic [CNT_W-1:0]          n_ma_r;
  logic [CNT_W-1:0]          n_load_r;
  logic [IDX_W-1:0]          rd_r;
  logic [IDX_W-1:0]          k_r;
  logic [lmmf_pkg::SUM_W-1:0] sum_r;
  logic [15:0]               buf_r [WIN];
  logic [15:0]               cand_r;
  logic [CNT_W-1:0]          m_r;
  logic [CNT_W-1:0]          j_r;
  logic [12:0]               tv_r;
  logic [lmmf_pkg::PROD_W-1:0] prod_r;

  lmmf_pkg::out_item_t out_r;
  logic                out_valid_r;

  // ---------------------------------------------------------------- combinational
  logic                  in_acc;
  logic                  fin_load;
  logic [CNT_W-1:0]      fill_new;
  logic [CNT_W-1:0]      wmed;
  logic [CNT_W-1:0]      wma;
  logic                  t_neg;
  logic [15:0]           t_abs;
  logic                  clamp_lo;
  logic                  clamp_hi;
  logic [lmmf_pkg::MUL_A_W-1:0] mul_a;
  logic [lmmf_pkg::MUL_B_W-1:0] mul_b;
  logic                  scan_last;
  logic [CNT_W-1:0]      med_target;
  logic [IDX_W-1:0]      wpos;
  logic [15:0]           loser;
  logic                  cand_up;
  logic [10:0]           t_quot;
  logic signed [17:0]    dist_sum;
  logic [15:0]           dist_sat;
  logic signed [11:0]    temp_fb;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign fin_load = (state_r == lmmf_pkg::ST_FIN) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == lmmf_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign fill_new = (fill_r < CNT_W'(WIN)) ? fill_r + CNT_W'(1) : fill_r;

  always_comb begin
    wmed = lmmf_pkg::clamp_win(median_win_r);
    if (!wmed[0]) begin
      wmed = wmed - CNT_W'(1);
    end
    wma = lmmf_pkg::clamp_win(mean_win_r);
  end

  assign t_neg = item_r.temperature_raw[15];
  assign t_abs = t_neg ? 16'(~item_r.temperature_raw + 16'd1) : item_r.temperature_raw;

  assign clamp_lo = t_neg  && (prod_r[31:0] > lmmf_pkg::PROD_LO_LIM);
  assign clamp_hi = !t_neg && (prod_r[31:0] > lmmf_pkg::PROD_HI_LIM);

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      lmmf_pkg::ST_TMUL: begin
        mul_a = {3'b000, t_abs};
        mul_b = {6'b000000, temp_scale_r};
      end
      lmmf_pkg::ST_TDIV: begin
        mul_a = {6'b000000, tv_r};
        mul_b = lmmf_pkg::DIV5_Q16;
      end
      lmmf_pkg::ST_MDIV: begin
        mul_a = sum_r;
        mul_b = lmmf_pkg::recip_q21(n_ma_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // median selection: each pass pulls the max out of the first m entries;
  // the max of the last pass (m = n/2 + 1) is sorted[n/2]
  assign med_target = (n_med_r >> 1) + CNT_W'(1);
  assign scan_last  = (j_r == m_r - CNT_W'(2));
  assign wpos       = IDX_W'(m_r - CNT_W'(2));
  assign cand_up    = buf_r[0] > cand_r;
  assign loser      = cand_up ? cand_r : buf_r[0];

  assign t_quot = prod_r[26:16];

  assign dist_sum = $signed({2'b00, (item_r.read_ok ? item_r.distance_raw : 16'd0)})
                  + $signed({{2{dist_ofs_r[15]}}, dist_ofs_r});
  always_comb begin
    if (dist_sum < 18'sd0) begin
      dist_sat = 16'd0;
    end else if (dist_sum > lmmf_pkg::DIST_MAX) begin
      dist_sat = 16'hFFFF;
    end else begin
      dist_sat = dist_sum[15:0];
    end
  end

  assign temp_fb = (last_temp_r == 12'sd0) ? lmmf_pkg::TEMP_DFLT : last_temp_r;

  // ---------------------------------------------------------------- state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lmmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_ch.data.read_ok ? lmmf_pkg::ST_TMUL : lmmf_pkg::ST_FIN;
        end
      end
      lmmf_pkg::ST_TMUL: state_nxt = lmmf_pkg::ST_TRND;
      lmmf_pkg::ST_TRND: begin
        state_nxt = (clamp_lo || clamp_hi) ? lmmf_pkg::ST_LOAD : lmmf_pkg::ST_TDIV;
      end
      lmmf_pkg::ST_TDIV: state_nxt = lmmf_pkg::ST_TFIN;
      lmmf_pkg::ST_TFIN: state_nxt = lmmf_pkg::ST_LOAD;
      lmmf_pkg::ST_LOAD: begin
        if (CNT_W'(k_r) == n_load_r - CNT_W'(1)) begin
          state_nxt = lmmf_pkg::ST_PICK;
        end
      end
      lmmf_pkg::ST_PICK: begin
        state_nxt = (m_r == CNT_W'(1)) ? lmmf_pkg::ST_MDIV : lmmf_pkg::ST_SCAN;
      end
      lmmf_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = (m_r == med_target) ? lmmf_pkg::ST_MDIV : lmmf_pkg::ST_PICK;
        end
      end
      lmmf_pkg::ST_MDIV: state_nxt = lmmf_pkg::ST_MFIN;
      lmmf_pkg::ST_MFIN: state_nxt = lmmf_pkg::ST_FIN;
      lmmf_pkg::ST_FIN: begin
        if (fin_load) begin
          state_nxt = lmmf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lmmf_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      median_win_r <= lmmf_pkg::MEDIAN_WIN_RST;
      mean_win_r   <= lmmf_pkg::MEAN_WIN_RST;
      temp_scale_r <= lmmf_pkg::TEMP_SCALE_RST;
      dist_ofs_r   <= lmmf_pkg::DIST_OFS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmmf_pkg::CFG_MEDIAN_WIN: median_win_r <= cfg_wdata[7:0];
        lmmf_pkg::CFG_MEAN_WIN:   mean_win_r   <= cfg_wdata[7:0];
        lmmf_pkg::CFG_TEMP_SCALE: temp_scale_r <= cfg_wdata;
        lmmf_pkg::CFG_DIST_OFS:   dist_ofs_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      ws_r          <= '0;
      last_median_r <= '0;
      last_mean_r   <= '0;
      last_temp_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc && in_ch.data.read_ok) begin
        fill_r <= fill_new;
        ws_r   <= (ws_r == IDX_W'(WIN - 1)) ? '0 : ws_r + IDX_W'(1);
      end
      if (state_r == lmmf_pkg::ST_TRND) begin
        if (clamp_hi) begin
          last_temp_r <= lmmf_pkg::TEMP_HI;
        end else if (clamp_lo) begin
          last_temp_r <= lmmf_pkg::TEMP_LO;
        end
      end
      if (state_r == lmmf_pkg::ST_TFIN) begin
        last_temp_r <= t_neg ? -$signed({1'b0, t_quot}) : $signed({1'b0, t_quot});
      end
      if (state_r == lmmf_pkg::ST_MFIN) begin
        last_median_r <= cand_r;
        last_mean_r   <= prod_r[36:21];
      end
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r   <= in_ch.data;
      n_med_r  <= (fill_new < wmed) ? fill_new : wmed;
      n_ma_r   <= (fill_new < wma) ? fill_new : wma;
      n_load_r <= fill_new;
      rd_r     <= ws_r;
      k_r      <= '0;
      sum_r    <= '0;
      if (in_ch.data.read_ok) begin
        dring_r[ws_r] <= in_ch.data.distance_raw;
        sring_r[ws_r] <= in_ch.data.strength_raw;
      end
    end

    if (state_r == lmmf_pkg::ST_TMUL || state_r == lmmf_pkg::ST_TDIV ||
        state_r == lmmf_pkg::ST_MDIV) begin
      prod_r <= lmmf_pkg::PROD_W'(mul_a) * lmmf_pkg::PROD_W'(mul_b);
    end

    // round half up on the magnitude, then /2560 = (>> 9) / 5
    if (state_r == lmmf_pkg::ST_TRND) begin
      tv_r <= 13'(({1'b0, prod_r[31:0]} + lmmf_pkg::ROUND_HALF) >> 9);
    end

    // newest entry first, walking back around the ring
    if (state_r == lmmf_pkg::ST_LOAD) begin
      buf_r[k_r] <= dring_r[rd_r];
      if (CNT_W'(k_r) < n_ma_r) begin
        sum_r <= sum_r + lmmf_pkg::SUM_W'(sring_r[rd_r]);
      end
      rd_r <= (rd_r == '0) ? IDX_W'(WIN - 1) : rd_r - IDX_W'(1);
      k_r  <= k_r + IDX_W'(1);
      m_r  <= n_med_r;
    end

    if (state_r == lmmf_pkg::ST_PICK || state_r == lmmf_pkg::ST_SCAN) begin
      for (int i = 0; i < WIN - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end

    if (state_r == lmmf_pkg::ST_PICK) begin
      cand_r <= buf_r[0];
      j_r    <= '0;
    end

    if (state_r == lmmf_pkg::ST_SCAN) begin
      buf_r[wpos] <= loser;
      if (cand_up) begin
        cand_r <= buf_r[0];
      end
      j_r <= j_r + CNT_W'(1);
      if (scan_last) begin
        m_r <= m_r - CNT_W'(1);
      end
    end

    if (fin_load) begin
      out_r.distance_out       <= dist_sat;
      out_r.strength_out       <= item_r.read_ok ? item_r.strength_raw : 16'd0;
      out_r.distance_filtered  <= last_median_r;
      out_r.strength_filtered  <= last_mean_r;
      out_r.temperature_tenths <= item_r.read_ok ? last_temp_r : temp_fb;
      out_r.frame_ready        <= item_r.read_ok;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WIN))
    else $error("fill count beyond ring depth");

  a_fail_direct: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.data.read_ok |=> state_r == lmmf_pkg::ST_FIN)
    else $error("failed reading did not go straight to result");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.temperature_tenths >= lmmf_pkg::TEMP_LO &&
                     out_r.temperature_tenths <= lmmf_pkg::TEMP_HI))
    else $error("temperature beat out of range");

  a_ring_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.data.read_ok && fill_r < CNT_W'(WIN) |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("fill count did not advance on good reading");

endmodule
